/* src/rpla_pkg.sv */
`default_nettype none
package rpla_pkg;

   localparam int HIST_DEPTH_DEF = 256;

   localparam int TOKEN_W     = 24;
   localparam int LOGIT_W     = 32;
   localparam int OP_W        = 2;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 25;
   localparam int PENALTY_W   = 16;
   localparam int WINDOW_W    = 9;
   localparam int VOCAB_W     = 25;

   // restoring divide of a 40-bit dividend (logit shifted by 8)
   localparam int DIV_STEPS = LOGIT_W + 8;
   localparam int DIV_CNT_W = 6;
   localparam int PROD_W    = LOGIT_W + PENALTY_W;

   localparam logic [OP_W-1:0] OP_OBSERVE = 2'd0;
   localparam logic [OP_W-1:0] OP_ADJUST  = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] REG_PENALTY = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_WINDOW  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_VOCAB   = 2'd2;

   localparam logic [PENALTY_W-1:0] PENALTY_ONE   = 16'd256;
   localparam logic [PENALTY_W-1:0] PENALTY_RESET = 16'd256;
   localparam logic [WINDOW_W-1:0]  WINDOW_RESET  = 9'd64;
   localparam logic [VOCAB_W-1:0]   VOCAB_RESET   = 25'd32000;

   typedef struct packed {
      logic load;      // latch item, set up scan
      logic observe;   // append token to history
      logic clear;     // empty history
      logic scan;      // walk the window
      logic prep;      // load divider, register product
      logic div_step;  // one quotient bit
      logic emit;      // load output register
   } rpla_cmd_type;

   typedef struct packed {
      logic scan_done;
      logic go_div;
      logic div_done;
      logic out_free;
   } rpla_sts_type;

endpackage
`default_nettype wire

/* src/rpla_if.sv */
`default_nettype none
interface rpla_req_if
   import rpla_pkg::*;
   ();
   logic                      valid;
   logic                      ready;
   logic [OP_W-1:0]           op;
   logic [TOKEN_W-1:0]        token;
   logic signed [LOGIT_W-1:0] logit_in;

   modport source (output valid, op, token, logit_in, input ready);
   modport sink   (input valid, op, token, logit_in, output ready);
endinterface

interface rpla_rsp_if
   import rpla_pkg::*;
   ();
   logic                      valid;
   logic                      ready;
   logic signed [LOGIT_W-1:0] logit_out;
   logic                      penalized;

   modport source (output valid, logit_out, penalized, input ready);
   modport sink   (input valid, logit_out, penalized, output ready);
endinterface

interface rpla_csr_if
   import rpla_pkg::*;
   ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* src/repeat_penalty_logit_adjuster_core.sv */
// Channel  | Dir | Handshake    | Payload
// ---------+-----+--------------+------------------------------------------
// req_chan | in  | valid/ready  | op[1:0], token[23:0], logit_in[31:0] s
// rsp_chan | out | valid/ready  | logit_out[31:0] s, penalized
// csr_chan | in  | valid/ready  | index[1:0], data[24:0] (ready always 1)
//
// Items: observe and clear items complete when accepted, and the block stays
//   ready. An adjust item scans W history entries, where W is the window
//   clipped to the fill level, through the history memory's single read port,
//   then runs the bit-serial divider when a positive logit is divided.
// Reset: synchronous, active high; empties the history, loads register
//   defaults. History contents are not cleared.
// Stalls: a finished result waits in the output register; new items are
//   accepted meanwhile, and a later adjust waits before its own emit.
`default_nettype none
module repeat_penalty_logit_adjuster_core
   import rpla_pkg::*;
#(
   parameter int HIST_DEPTH = HIST_DEPTH_DEF
)(
   input wire logic clock,
   input wire logic reset,
   rpla_req_if.sink   req_chan,
   rpla_rsp_if.source rsp_chan,
   rpla_csr_if.sink   csr_chan
);

   rpla_cmd_type cmd;
   rpla_sts_type sts;

   // registers take a write in any cycle
   assign csr_chan.ready = 1'b1;

   // sequencer: accept, scan, decide, divide, emit
   rpla_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_op    (req_chan.op),
      .req_ready (req_chan.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   // history ring, window scan, divider, multiplier, output register
   rpla_dpath #(
      .HIST_DEPTH (HIST_DEPTH)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .tok_in    (req_chan.token),
      .logit_in  (req_chan.logit_in),
      .csr_write (csr_chan.valid),
      .csr_index (csr_chan.index),
      .csr_data  (csr_chan.data),
      .rsp_ready (rsp_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .logit_out (rsp_chan.logit_out),
      .penalized (rsp_chan.penalized)
   );

endmodule
`default_nettype wire

/* src/rpla_ctrl.sv */
`default_nettype none
module rpla_ctrl
   import rpla_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   input  wire logic [OP_W-1:0] req_op,
   output      logic            req_ready,
   output      rpla_cmd_type    cmd,
   input  wire rpla_sts_type    sts
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_DIV,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      cmd          = '0;
      cmd.load     = accept;
      cmd.scan     = (state_ff == ST_SCAN);
      cmd.prep     = (state_ff == ST_DECIDE);
      cmd.div_step = (state_ff == ST_DIV);
      cmd.emit     = (state_ff == ST_EMIT) && sts.out_free;
      state_in     = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_op)
                  OP_OBSERVE: cmd.observe = 1'b1;
                  OP_CLEAR:   cmd.clear   = 1'b1;
                  OP_ADJUST:  state_in    = ST_SCAN;
                  default:    ;  // undefined op dropped
               endcase
            end
         end
         ST_SCAN:   if (sts.scan_done) state_in = ST_DECIDE;
         ST_DECIDE: state_in = sts.go_div ? ST_DIV : ST_EMIT;
         ST_DIV:    if (sts.div_done) state_in = ST_EMIT;
         ST_EMIT:   if (sts.out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

/* src/rpla_dpath.sv */
`default_nettype none
module rpla_dpath
   import rpla_pkg::*;
#(
   parameter int HIST_DEPTH = HIST_DEPTH_DEF
)(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire rpla_cmd_type              cmd,
   output      rpla_sts_type              sts,
   input  wire logic [TOKEN_W-1:0]        tok_in,
   input  wire logic signed [LOGIT_W-1:0] logit_in,
   input  wire logic                      csr_write,
   input  wire logic [CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [CSR_DATA_W-1:0]     csr_data,
   input  wire logic                      rsp_ready,
   output      logic                      rsp_valid,
   output      logic signed [LOGIT_W-1:0] logit_out,
   output      logic                      penalized
);

   localparam int AW = $clog2(HIST_DEPTH);
   localparam int FW = AW + 1;
   localparam int CW = (FW > WINDOW_W) ? FW : WINDOW_W;
   localparam logic [FW-1:0] DEPTH_F = FW'(HIST_DEPTH);
   localparam logic [AW-1:0] LAST_A  = AW'(HIST_DEPTH - 1);

   // configuration
   logic [PENALTY_W-1:0] pen_ff;
   logic [WINDOW_W-1:0]  win_ff;
   logic [VOCAB_W-1:0]   vocab_ff;

   // history ring
   logic [TOKEN_W-1:0] mem [HIST_DEPTH];
   logic [FW-1:0]      fill_ff;
   logic [AW-1:0]      oldest_ff;

   // item and scan
   logic [TOKEN_W-1:0] tok_ff;
   logic [LOGIT_W-1:0] logit_ff;
   logic               gate_ff;
   logic               found_ff;
   logic [AW-1:0]      rd_ptr_ff;
   logic [FW-1:0]      remain_ff;
   logic               rd_pend_ff;
   logic [TOKEN_W-1:0] rd_data_ff;

   // arithmetic
   logic [DIV_STEPS-1:0] quo_ff;
   logic [PENALTY_W-1:0] rem_ff;
   logic [DIV_CNT_W-1:0] div_cnt_ff;
   logic [PROD_W-1:0]    prod_ff;

   // output register
   logic               rsp_valid_ff;
   logic [LOGIT_W-1:0] logit_out_ff;
   logic               pen_out_ff;

   logic [CW-1:0]      win_ext, fill_ext;
   logic [FW-1:0]      w_eff;
   logic [FW-1:0]      start_sum, start_ptr;
   logic [FW-1:0]      wr_sum, wr_ptr;
   logic               rd_en;
   logic [AW-1:0]      rd_ptr_next;
   logic [PENALTY_W:0] rem_sh, rem_diff;
   logic               q_bit;
   logic [LOGIT_W-1:0] mag;
   logic [DIV_STEPS-1:0] prod_sh;
   logic [LOGIT_W-1:0] prod_sat;
   logic               penalize;
   logic [LOGIT_W-1:0] result;

   // window clipped to the fill level; 0 selects the whole history
   assign win_ext  = CW'(win_ff);
   assign fill_ext = CW'(fill_ff);
   assign w_eff    = (win_ff == '0 || win_ext > fill_ext) ? fill_ff : FW'(win_ext);

   assign start_sum = FW'({1'b0, oldest_ff}) + (fill_ff - w_eff);
   assign start_ptr = (start_sum >= DEPTH_F) ? start_sum - DEPTH_F : start_sum;
   assign wr_sum    = FW'({1'b0, oldest_ff}) + fill_ff;
   assign wr_ptr    = (wr_sum >= DEPTH_F) ? wr_sum - DEPTH_F : wr_sum;

   assign rd_en       = cmd.scan && (remain_ff != '0);
   assign rd_ptr_next = (rd_ptr_ff == LAST_A) ? '0 : rd_ptr_ff + 1'b1;

   assign rem_sh   = {rem_ff, quo_ff[DIV_STEPS-1]};
   assign rem_diff = rem_sh - {1'b0, pen_ff};
   assign q_bit    = (rem_sh >= {1'b0, pen_ff});

   assign mag      = '0 - logit_ff;
   assign prod_sh  = prod_ff[PROD_W-1:8];
   assign prod_sat = (prod_sh > DIV_STEPS'(33'h080000000)) ? 32'h80000000 :
                     prod_sh[LOGIT_W-1:0];

   assign penalize = found_ff && gate_ff;

   always_comb begin
      if (!penalize || logit_ff == '0) begin
         result = logit_ff;
      end else if (!logit_ff[LOGIT_W-1]) begin
         result = quo_ff[LOGIT_W-1:0];
      end else begin
         result = '0 - prod_sat;
      end
   end

   always_comb begin
      sts.scan_done = (remain_ff == '0) && !rd_pend_ff;
      sts.go_div    = penalize && !logit_ff[LOGIT_W-1] && (logit_ff != '0);
      sts.div_done  = (div_cnt_ff == '0);
      sts.out_free  = !rsp_valid_ff || rsp_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pen_ff   <= PENALTY_RESET;
         win_ff   <= WINDOW_RESET;
         vocab_ff <= VOCAB_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_PENALTY: pen_ff   <= csr_data[PENALTY_W-1:0];
            REG_WINDOW:  win_ff   <= csr_data[WINDOW_W-1:0];
            REG_VOCAB:   vocab_ff <= csr_data[VOCAB_W-1:0];
            default:     ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff   <= '0;
         oldest_ff <= '0;
      end else if (cmd.clear) begin
         fill_ff   <= '0;
         oldest_ff <= '0;
      end else if (cmd.observe) begin
         if (fill_ff < DEPTH_F) begin
            fill_ff <= fill_ff + 1'b1;
         end else begin
            oldest_ff <= (oldest_ff == LAST_A) ? '0 : oldest_ff + 1'b1;
         end
      end
   end

   // history storage, one write or one read per cycle
   always_ff @(posedge clock) begin
      if (cmd.observe) begin
         mem[wr_ptr[AW-1:0]] <= tok_in;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_ptr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         tok_ff    <= tok_in;
         logit_ff  <= logit_in;
         rd_ptr_ff <= start_ptr[AW-1:0];
      end else if (rd_en) begin
         rd_ptr_ff <= rd_ptr_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remain_ff  <= '0;
         rd_pend_ff <= 1'b0;
         found_ff   <= 1'b0;
         gate_ff    <= 1'b0;
      end else if (cmd.load) begin
         remain_ff  <= w_eff;
         rd_pend_ff <= 1'b0;
         found_ff   <= 1'b0;
         gate_ff    <= (pen_ff > PENALTY_ONE) && ({1'b0, tok_in} < vocab_ff);
      end else if (cmd.scan) begin
         rd_pend_ff <= rd_en;
         if (rd_en) begin
            remain_ff <= remain_ff - 1'b1;
         end
         if (rd_pend_ff && rd_data_ff == tok_ff) begin
            found_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         quo_ff  <= {logit_ff, 8'h00};
         rem_ff  <= '0;
         prod_ff <= mag * pen_ff;
      end else if (cmd.div_step && div_cnt_ff != '0) begin
         quo_ff <= {quo_ff[DIV_STEPS-2:0], q_bit};
         rem_ff <= q_bit ? rem_diff[PENALTY_W-1:0] : rem_sh[PENALTY_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_cnt_ff <= '0;
      end else if (cmd.prep) begin
         div_cnt_ff <= DIV_CNT_W'(DIV_STEPS);
      end else if (cmd.div_step && div_cnt_ff != '0) begin
         div_cnt_ff <= div_cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         logit_out_ff <= result;
         pen_out_ff   <= penalize;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign logit_out = logit_out_ff;
   assign penalized = pen_out_ff;

endmodule
`default_nettype wire

/* src/rpla_checker.sv */
`default_nettype none
module rpla_checker
   import rpla_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   rpla_req_if.sink   req_chan,
   rpla_rsp_if.source rsp_chan
);

   // held result does not change
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.ready |=>
         rsp_chan.valid && $stable(rsp_chan.logit_out) && $stable(rsp_chan.penalized))
      else $error("result changed while stalled");

   // no result straight out of reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_chan.valid)
      else $error("result valid after reset");

   // an adjust keeps the block busy while it scans
   a_adjust_busy: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready && req_chan.op == OP_ADJUST |=> !req_chan.ready)
      else $error("ready during adjust");

   // observe and clear leave the block ready for the next item
   a_short_ops: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready &&
      (req_chan.op == OP_OBSERVE || req_chan.op == OP_CLEAR) |=> req_chan.ready)
      else $error("observe or clear stalled input");

endmodule

bind repeat_penalty_logit_adjuster_core rpla_checker u_rpla_checker (
   .clock    (clock),
   .reset    (reset),
   .req_chan (req_chan),
   .rsp_chan (rsp_chan)
);
`default_nettype wire
